// File: sv/ubx_frame_receiver_defines.svh
// Assertion macros shared by the UBX frame receiver RTL.
// Depends on nothing; users provide clk and rst in scope.
`ifndef UBX_FRAME_RECEIVER_DEFINES_SVH
`define UBX_FRAME_RECEIVER_DEFINES_SVH
`ifndef ASSERT_OFF
// Check a condition on every clock outside reset.
`define UBX_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("ubx assertion failed");
// Check that a trigger implies a consequence in the next cycle.
`define UBX_ASSERT_NEXT(label, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("ubx assertion failed");
`else
`define UBX_ASSERT(label, cond)
`define UBX_ASSERT_NEXT(label, trig, cons)
`endif
`endif

// File: sv/ubxfr_pkg.sv
// Shared constants for the UBX frame receiver: sync bytes, event codes,
// buffer size. No dependencies.
package ubxfr_pkg;

  // Size of the consumer's payload buffer, 1 to 511 (stored_count is 9 bits)
  localparam int BUFFER_BYTES = 256;

  localparam logic [7:0] SYNC_CHAR_1 = 8'hB5;
  localparam logic [7:0] SYNC_CHAR_2 = 8'h62;

  localparam logic [1:0] EV_BYTE   = 2'd0;
  localparam logic [1:0] EV_ACCEPT = 2'd1;
  localparam logic [1:0] EV_REJECT = 2'd2;

endpackage

// File: sv/ubx_frame_receiver.sv
// UBX frame receiver: sync hunt, header capture, Fletcher-8 check, payload beats.
// Each accepted byte's result beat is registered in the next cycle; 1 byte per cycle unless stalled.
// The parser state and the output register sit one update apart, so a new byte is
// taken each cycle unless a result beat is stalled. Synchronous active-high reset
// returns the parser to sync hunting with cleared sums and no pending result.
// Depends on ubxfr_pkg and ubx_frame_receiver_defines.svh.
`include "ubx_frame_receiver_defines.svh"

module ubx_frame_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  event_kind,
  output logic [7:0]  msg_class,
  output logic [7:0]  msg_id,
  output logic [15:0] payload_length,
  output logic [15:0] payload_index,
  output logic [7:0]  data_byte,
  output logic        kept,
  output logic [8:0]  stored_count
);

  typedef enum logic [3:0] {
    PH_SYNC1   = 4'd0,
    PH_SYNC2   = 4'd1,
    PH_CLASS   = 4'd2,
    PH_ID      = 4'd3,
    PH_LEN1    = 4'd4,
    PH_LEN2    = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CKA     = 4'd7,
    PH_CKB     = 4'd8
  } phase_t;

  localparam logic [16:0] BUF_LIMIT = 17'(ubxfr_pkg::BUFFER_BYTES);

  phase_t      phase, phase_next;
  logic [7:0]  sum_a, sum_a_next;
  logic [7:0]  sum_b, sum_b_next;
  logic [15:0] frame_length, frame_length_next;
  logic [15:0] bytes_seen, bytes_seen_next;
  logic [7:0]  held_class, held_class_next;
  logic [7:0]  held_id, held_id_next;

  logic        res_valid;
  logic [1:0]  res_kind;
  logic [15:0] res_index;
  logic [7:0]  res_data;
  logic        res_kept;
  logic [8:0]  res_count;

  logic        in_fire;
  logic [7:0]  add_a;
  logic [16:0] idx_plus;
  logic [16:0] len_ext;
  logic [16:0] len_clamp;
  logic [16:0] idx_clamp;

  logic        byte_beat;
  logic        end_clean;
  logic        resynced;

  // Take a byte whenever the output register is free or draining
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Fletcher step and buffer clamps
  assign add_a     = sum_a + rx_byte;
  assign idx_plus  = {1'b0, bytes_seen} + 17'd1;
  assign len_ext   = {1'b0, frame_length};
  assign len_clamp = (len_ext < BUF_LIMIT) ? len_ext : BUF_LIMIT;
  assign idx_clamp = (idx_plus < BUF_LIMIT) ? idx_plus : BUF_LIMIT;

  // Advance the parser for one byte
  always_comb begin
    phase_next        = phase;
    sum_a_next        = sum_a;
    sum_b_next        = sum_b;
    frame_length_next = frame_length;
    bytes_seen_next   = bytes_seen;
    held_class_next   = held_class;
    held_id_next      = held_id;
    res_valid         = 1'b0;
    res_kind          = ubxfr_pkg::EV_BYTE;
    res_index         = '0;
    res_data          = '0;
    res_kept          = 1'b0;
    res_count         = len_clamp[8:0];
    unique case (phase)
      PH_SYNC2: begin
        phase_next = (rx_byte == ubxfr_pkg::SYNC_CHAR_2) ? PH_CLASS : PH_SYNC1;
      end
      PH_CLASS: begin
        held_class_next = rx_byte;
        sum_a_next      = rx_byte;
        sum_b_next      = rx_byte;
        phase_next      = PH_ID;
      end
      PH_ID: begin
        held_id_next = rx_byte;
        sum_a_next   = add_a;
        sum_b_next   = sum_b + add_a;
        phase_next   = PH_LEN1;
      end
      PH_LEN1: begin
        frame_length_next = {8'd0, rx_byte};
        sum_a_next        = add_a;
        sum_b_next        = sum_b + add_a;
        phase_next        = PH_LEN2;
      end
      PH_LEN2: begin
        frame_length_next = {rx_byte, frame_length[7:0]};
        sum_a_next        = add_a;
        sum_b_next        = sum_b + add_a;
        bytes_seen_next   = '0;
        phase_next = ({rx_byte, frame_length[7:0]} == 16'd0) ? PH_CKA : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        sum_a_next      = add_a;
        sum_b_next      = sum_b + add_a;
        res_valid       = 1'b1;
        res_kind        = ubxfr_pkg::EV_BYTE;
        res_index       = bytes_seen;
        res_data        = rx_byte;
        res_kept        = ({1'b0, bytes_seen} < BUF_LIMIT);
        res_count       = idx_clamp[8:0];
        bytes_seen_next = idx_plus[15:0];
        if (idx_plus >= len_ext) begin
          phase_next = PH_CKA;
        end
      end
      PH_CKA: begin
        if (rx_byte != sum_a) begin
          res_valid = 1'b1;
          res_kind  = ubxfr_pkg::EV_REJECT;
        end else begin
          phase_next = PH_CKB;
        end
      end
      PH_CKB: begin
        res_valid = 1'b1;
        res_kind  = (rx_byte == sum_b) ? ubxfr_pkg::EV_ACCEPT : ubxfr_pkg::EV_REJECT;
      end
      default: begin
        phase_next = (rx_byte == ubxfr_pkg::SYNC_CHAR_1) ? PH_SYNC2 : PH_SYNC1;
      end
    endcase
    // Drop frame state once a frame end result goes out
    if (res_valid && res_kind != ubxfr_pkg::EV_BYTE) begin
      phase_next        = PH_SYNC1;
      sum_a_next        = '0;
      sum_b_next        = '0;
      frame_length_next = '0;
      bytes_seen_next   = '0;
    end
  end

  // Hold parser state and the result register; update on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SYNC1;
      sum_a        <= '0;
      sum_b        <= '0;
      frame_length <= '0;
      bytes_seen   <= '0;
      held_class   <= '0;
      held_id      <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (in_fire) begin
        phase        <= phase_next;
        sum_a        <= sum_a_next;
        sum_b        <= sum_b_next;
        frame_length <= frame_length_next;
        bytes_seen   <= bytes_seen_next;
        held_class   <= held_class_next;
        held_id      <= held_id_next;
      end
      // Load a new result beat, or clear once taken
      if (in_fire && res_valid) begin
        out_valid      <= 1'b1;
        event_kind     <= res_kind;
        msg_class      <= held_class;
        msg_id         <= held_id;
        payload_length <= frame_length;
        payload_index  <= res_index;
        data_byte      <= res_data;
        kept           <= res_kept;
        stored_count   <= res_count;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Conditions watched by the checks below
  assign byte_beat = out_valid && (event_kind == ubxfr_pkg::EV_BYTE);
  assign end_clean = (payload_index == 16'd0) && (data_byte == 8'd0) && !kept;
  assign resynced  = (phase == PH_SYNC1) && (sum_a == 8'd0) && (sum_b == 8'd0);

  `UBX_ASSERT(a_payload_in_range, (phase != PH_PAYLOAD) || (bytes_seen < frame_length))
  `UBX_ASSERT_NEXT(a_payload_beat, in_fire && (phase == PH_PAYLOAD), byte_beat)
  `UBX_ASSERT(a_end_fields_zero, !out_valid || byte_beat || end_clean)
  `UBX_ASSERT_NEXT(a_ckb_resync, in_fire && (phase == PH_CKB), out_valid && resynced)

endmodule
